[design/nss_pkg.sv]
// Package for the nested separator splitter.
// Holds the scan mode codes, the special byte values and the types shared by all modules.
// Depends on nothing.
`default_nettype none

package nss_pkg;

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_SQUARE = 3'd1;
    localparam logic [2:0] MODE_ROUND  = 3'd2;
    localparam logic [2:0] MODE_CURLY  = 3'd3;
    localparam logic [2:0] MODE_QUOTE  = 3'd4;

    localparam logic [7:0] CH_SQ_OPEN  = 8'h5B;
    localparam logic [7:0] CH_SQ_CLOSE = 8'h5D;
    localparam logic [7:0] CH_RD_OPEN  = 8'h28;
    localparam logic [7:0] CH_RD_CLOSE = 8'h29;
    localparam logic [7:0] CH_CU_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CU_CLOSE = 8'h7D;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;

    localparam logic [7:0] SEPARATOR_RESET = 8'd44;

    typedef struct packed {
        logic [2:0] mode;
        logic       prev_backslash;
        logic       depth_overflow;
    } scan_flags_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       split;
        logic       end_of_text;
        logic       unclosed_error;
    } out_result_t;

endpackage

`default_nettype wire

[design/nss_scan_step.sv]
// Next-state and result logic for one text byte of the splitter.
// Depends on nss_pkg for mode codes, byte values and shared types.
`default_nettype none

module nss_scan_step #(
    parameter int MAX_DEPTH = 255,
    parameter int DEPTH_W   = 8
) (
    input  wire logic [7:0]           text_byte,
    input  wire logic                 is_last,
    input  wire logic [7:0]           separator,
    input  wire nss_pkg::scan_flags_t flags_cur,
    input  wire logic [DEPTH_W-1:0]   depth_cur,
    output nss_pkg::scan_flags_t      flags_next,
    output logic [DEPTH_W-1:0]        depth_next,
    output nss_pkg::out_result_t      result
);

    logic [7:0] opener;
    logic [7:0] closer;
    logic       in_bracket;
    logic       split_hit;

    always_comb
    begin
        opener     = '0;
        closer     = '0;
        in_bracket = 1'b0;
        unique case (flags_cur.mode)
            nss_pkg::MODE_SQUARE:
            begin
                opener     = nss_pkg::CH_SQ_OPEN;
                closer     = nss_pkg::CH_SQ_CLOSE;
                in_bracket = 1'b1;
            end
            nss_pkg::MODE_ROUND:
            begin
                opener     = nss_pkg::CH_RD_OPEN;
                closer     = nss_pkg::CH_RD_CLOSE;
                in_bracket = 1'b1;
            end
            nss_pkg::MODE_CURLY:
            begin
                opener     = nss_pkg::CH_CU_OPEN;
                closer     = nss_pkg::CH_CU_CLOSE;
                in_bracket = 1'b1;
            end
            default:
            begin
                opener     = '0;
                closer     = '0;
                in_bracket = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        flags_next = flags_cur;
        depth_next = depth_cur;
        split_hit  = 1'b0;

        if (in_bracket)
        begin
            if (text_byte == closer)
            begin
                if (depth_cur == '0)
                begin
                    flags_next.mode = nss_pkg::MODE_NORMAL;
                end
                else
                begin
                    depth_next = depth_cur - DEPTH_W'(1);
                end
            end
            else if (text_byte == opener)
            begin
                if (depth_cur >= DEPTH_W'(MAX_DEPTH))
                begin
                    flags_next.depth_overflow = 1'b1;
                end
                else
                begin
                    depth_next = depth_cur + DEPTH_W'(1);
                end
            end
        end
        else if (flags_cur.mode == nss_pkg::MODE_QUOTE)
        begin
            if ((text_byte == nss_pkg::CH_DQUOTE) && !flags_cur.prev_backslash)
            begin
                flags_next.mode = nss_pkg::MODE_NORMAL;
            end
        end
        else
        begin
            if (text_byte == nss_pkg::CH_SQ_OPEN)
            begin
                flags_next.mode = nss_pkg::MODE_SQUARE;
                depth_next      = '0;
            end
            else if (text_byte == nss_pkg::CH_RD_OPEN)
            begin
                flags_next.mode = nss_pkg::MODE_ROUND;
                depth_next      = '0;
            end
            else if (text_byte == nss_pkg::CH_CU_OPEN)
            begin
                flags_next.mode = nss_pkg::MODE_CURLY;
                depth_next      = '0;
            end
            else if (text_byte == nss_pkg::CH_DQUOTE)
            begin
                flags_next.mode = nss_pkg::MODE_QUOTE;
            end
            else if (text_byte == separator)
            begin
                split_hit = 1'b1;
            end
        end

        flags_next.prev_backslash = (text_byte == nss_pkg::CH_BSLASH);

        result.out_byte       = text_byte;
        result.split          = split_hit;
        result.end_of_text    = is_last;
        result.unclosed_error = is_last && (flags_next.depth_overflow ||
                                (flags_next.mode == nss_pkg::MODE_SQUARE) ||
                                (flags_next.mode == nss_pkg::MODE_ROUND) ||
                                (flags_next.mode == nss_pkg::MODE_CURLY));

        // The final byte of a text leaves the scanner ready for the next text.
        if (is_last)
        begin
            flags_next.mode           = nss_pkg::MODE_NORMAL;
            flags_next.prev_backslash = 1'b0;
            flags_next.depth_overflow = 1'b0;
            depth_next                = '0;
        end
    end

endmodule

`default_nettype wire

[design/nss_out_stage.sv]
// Result register of the splitter with its valid and ready handshake.
// Depends on nss_pkg for the result type.
`default_nettype none

module nss_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire nss_pkg::out_result_t result_in,
    input  wire logic                 out_ready,
    output logic                      can_load,
    output logic                      out_valid,
    output nss_pkg::out_result_t      result_out
);

    logic                 valid_reg;
    logic                 valid_next;
    nss_pkg::out_result_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

`default_nettype wire

[design/nested_separator_splitter_core.sv]
// Nested separator splitter: marks top-level separator bytes in a byte stream.
// The result of an accepted request is held in the output register from the next cycle.
// Throughput is one request per cycle; the output register alone sets the stall path.
// Reset clears the scan state and the output valid, and sets the separator to a comma.
// Depends on nss_pkg, nss_scan_step and nss_out_stage.
`default_nettype none

module nested_separator_splitter_core #(
    parameter int MAX_DEPTH = 255
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       is_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            split,
    output logic            end_of_text,
    output logic            unclosed_error
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    logic [7:0]           separator_reg;
    nss_pkg::scan_flags_t flags_reg;
    nss_pkg::scan_flags_t flags_next;
    logic [DEPTH_W-1:0]   depth_reg;
    logic [DEPTH_W-1:0]   depth_next;
    nss_pkg::out_result_t step_result;
    nss_pkg::out_result_t out_result;
    logic                 accept;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= nss_pkg::SEPARATOR_RESET;
        end
        else if (cfg_valid)
        begin
            separator_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg.mode           <= nss_pkg::MODE_NORMAL;
            flags_reg.prev_backslash <= 1'b0;
            flags_reg.depth_overflow <= 1'b0;
            depth_reg                <= '0;
        end
        else if (accept)
        begin
            flags_reg <= flags_next;
            depth_reg <= depth_next;
        end
    end

    nss_scan_step #(
        .MAX_DEPTH (MAX_DEPTH),
        .DEPTH_W   (DEPTH_W)
    ) u_scan_step (
        .text_byte  (text_byte),
        .is_last    (is_last),
        .separator  (separator_reg),
        .flags_cur  (flags_reg),
        .depth_cur  (depth_reg),
        .flags_next (flags_next),
        .depth_next (depth_next),
        .result     (step_result)
    );

    nss_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result_in  (step_result),
        .out_ready  (out_ready),
        .can_load   (in_ready),
        .out_valid  (out_valid),
        .result_out (out_result)
    );

    assign out_byte       = out_result.out_byte;
    assign split          = out_result.split;
    assign end_of_text    = out_result.end_of_text;
    assign unclosed_error = out_result.unclosed_error;

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for nested_separator_splitter_core.
// It predicts split and error flags for every accepted request and compares each result.
// Depends on nss_pkg and the nested_separator_splitter_core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH_LIMIT    = 255;
    localparam int WATCHDOG_LIMIT = 4000;

    class split_scoreboard;
        logic [7:0]           separator;
        logic [2:0]           mode;
        logic [7:0]           depth;
        bit                   prev_backslash;
        bit                   overflow;
        nss_pkg::out_result_t expected_marks[$];
        int                   errors;

        function new();
            separator = nss_pkg::SEPARATOR_RESET;
            errors = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            mode = nss_pkg::MODE_NORMAL;
            depth = 8'd0;
            prev_backslash = 1'b0;
            overflow = 1'b0;
        endfunction

        function void set_separator(logic [7:0] value);
            separator = value;
        endfunction

        function void nest_byte(logic [7:0] b, logic [7:0] opener, logic [7:0] closer);
            if (b == closer)
            begin
                if (depth == 8'd0)
                    mode = nss_pkg::MODE_NORMAL;
                else
                    depth = depth - 8'd1;
            end
            else if (b == opener)
            begin
                if (int'(depth) >= DEPTH_LIMIT)
                    overflow = 1'b1;
                else
                    depth = depth + 8'd1;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            nss_pkg::out_result_t mark;
            mark.out_byte = b;
            mark.split = 1'b0;
            mark.end_of_text = last;
            mark.unclosed_error = 1'b0;
            case (mode)
                nss_pkg::MODE_SQUARE: nest_byte(b, nss_pkg::CH_SQ_OPEN, nss_pkg::CH_SQ_CLOSE);
                nss_pkg::MODE_ROUND:  nest_byte(b, nss_pkg::CH_RD_OPEN, nss_pkg::CH_RD_CLOSE);
                nss_pkg::MODE_CURLY:  nest_byte(b, nss_pkg::CH_CU_OPEN, nss_pkg::CH_CU_CLOSE);
                nss_pkg::MODE_QUOTE:
                begin
                    if (b == nss_pkg::CH_DQUOTE && !prev_backslash)
                        mode = nss_pkg::MODE_NORMAL;
                end
                default:
                begin
                    if (b == nss_pkg::CH_SQ_OPEN)
                    begin
                        mode = nss_pkg::MODE_SQUARE;
                        depth = 8'd0;
                    end
                    else if (b == nss_pkg::CH_RD_OPEN)
                    begin
                        mode = nss_pkg::MODE_ROUND;
                        depth = 8'd0;
                    end
                    else if (b == nss_pkg::CH_CU_OPEN)
                    begin
                        mode = nss_pkg::MODE_CURLY;
                        depth = 8'd0;
                    end
                    else if (b == nss_pkg::CH_DQUOTE)
                        mode = nss_pkg::MODE_QUOTE;
                    else if (b == separator)
                        mark.split = 1'b1;
                end
            endcase
            prev_backslash = (b == nss_pkg::CH_BSLASH);
            if (last)
            begin
                mark.unclosed_error = overflow || mode == nss_pkg::MODE_SQUARE ||
                                      mode == nss_pkg::MODE_ROUND ||
                                      mode == nss_pkg::MODE_CURLY;
                clear_scan();
            end
            expected_marks.insert(expected_marks.size(), mark);
        endfunction

        function void compare_field(string name, int expected, int actual);
            if (expected != actual)
            begin
                $error("%s: expected %0d, got %0d", name, expected, actual);
                errors++;
            end
        endfunction

        function void check_mark(nss_pkg::out_result_t got);
            nss_pkg::out_result_t want;
            if (expected_marks.size() == 0)
            begin
                $error("result with no pending request: out_byte %0d", got.out_byte);
                errors++;
                return;
            end
            want = expected_marks.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("split", want.split, got.split);
            compare_field("end_of_text", want.end_of_text, got.end_of_text);
            compare_field("unclosed_error", want.unclosed_error, got.unclosed_error);
        endfunction

        function int pending();
            return expected_marks.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] text_byte = 8'd0;
    logic       is_last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       split;
    logic       end_of_text;
    logic       unclosed_error;

    split_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int sent_count = 0;
    int quiet_cycles = 0;

    nested_separator_splitter_core #(
        .MAX_DEPTH(DEPTH_LIMIT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .text_byte(text_byte),
        .is_last(is_last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .split(split),
        .end_of_text(end_of_text),
        .unclosed_error(unclosed_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** nested_separator_splitter_core: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_mark({out_byte, split, end_of_text, unclosed_error});
        end
    end

    task automatic write_separator(logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_separator(value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_request(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        is_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b, last);
        sent_count++;
    endtask

    task automatic send_text(string s, bit close_text);
        for (int i = 0; i < s.len(); i++)
            send_request(s[i], close_text && i == s.len() - 1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(13))
            0:       return nss_pkg::CH_SQ_OPEN;
            1:       return nss_pkg::CH_SQ_CLOSE;
            2:       return nss_pkg::CH_RD_OPEN;
            3:       return nss_pkg::CH_RD_CLOSE;
            4:       return nss_pkg::CH_CU_OPEN;
            5:       return nss_pkg::CH_CU_CLOSE;
            6:       return nss_pkg::CH_DQUOTE;
            7:       return nss_pkg::CH_BSLASH;
            8, 9:    return sb.separator;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_text();
        int  len;
        bit  noise;
        len = $urandom_range(1, 24);
        noise = ($urandom_range(9) == 0);
        for (int i = 0; i < len; i++)
        begin
            if (noise)
                send_request(8'($urandom_range(255)), $urandom_range(7) == 0);
            else
                send_request(pick_text_byte(), i == len - 1);
        end
    endtask

    task automatic send_deep_nest(bit full_close);
        logic [7:0] opener;
        logic [7:0] closer;
        case ($urandom_range(2))
            0:
            begin
                opener = nss_pkg::CH_SQ_OPEN;
                closer = nss_pkg::CH_SQ_CLOSE;
            end
            1:
            begin
                opener = nss_pkg::CH_RD_OPEN;
                closer = nss_pkg::CH_RD_CLOSE;
            end
            default:
            begin
                opener = nss_pkg::CH_CU_OPEN;
                closer = nss_pkg::CH_CU_CLOSE;
            end
        endcase
        send_request(opener, 1'b0);
        repeat (DEPTH_LIMIT + 1)
            send_request(opener, 1'b0);
        if (full_close)
            repeat (DEPTH_LIMIT + 1)
                send_request(closer, 1'b0);
        send_request(sb.separator, 1'b0);
        send_request(pick_text_byte(), 1'b1);
    endtask

    task automatic run_phase(int n_items, int send_pct, int recv_pct);
        int target;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        target = sent_count + n_items;
        while (sent_count < target)
            send_random_text();
        drain();
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_separator(nss_pkg::SEPARATOR_RESET);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_text(",[,[]](,){", 1'b1);
        send_text("\"\\\"\\\\\"\",\"", 1'b1);
        send_text("([", 1'b1);
        drain();
        write_separator(nss_pkg::CH_SQ_OPEN);
        send_text("[,]", 1'b1);
        drain();

        write_separator(nss_pkg::SEPARATOR_RESET);
        send_deep_nest(1'b1);
        run_phase(250, 0, 0);

        write_separator(8'h00);
        run_phase(250, 82, 0);

        write_separator(nss_pkg::CH_DQUOTE);
        hold_request = 300;
        run_phase(150, 0, 0);

        write_separator(8'hFF);
        run_phase(250, 0, 82);

        write_separator(8'($urandom_range(255)));
        send_deep_nest(1'b0);
        run_phase(250, 16, 16);

        in_valid <= 1'b0;
        drain();
        repeat (10)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** nested_separator_splitter_core: PASSED **");
        else
            $display("** nested_separator_splitter_core: FAILED **");
        $finish;
    end
endmodule
